>>> design/usart_ri_pkg.sv
// Shared types and constants for the USART register interface.
// Used by usart_ri_regs and usart_register_interface_top; no dependencies.
package usart_ri_pkg;

  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_RX    = 3'd2;
  localparam logic [2:0] REQ_POWER = 3'd3;
  localparam logic [2:0] REQ_FRAME = 3'd4;

  localparam logic [2:0] OFF_CTRL_A    = 3'd0;
  localparam logic [2:0] OFF_CTRL_B    = 3'd1;
  localparam logic [2:0] OFF_CTRL_C    = 3'd2;
  localparam logic [2:0] OFF_BAUD_LOW  = 3'd4;
  localparam logic [2:0] OFF_BAUD_HIGH = 3'd5;
  localparam logic [2:0] OFF_DATA      = 3'd6;

  localparam logic [1:0] CFG_RX_PIN  = 2'd0;
  localparam logic [1:0] CFG_RX_PORT = 2'd1;
  localparam logic [1:0] CFG_TX_PIN  = 2'd2;
  localparam logic [1:0] CFG_TX_PORT = 2'd3;

  // Register A bits
  localparam int A_RXC = 7;
  localparam int A_TXC = 6;
  localparam int A_DRE = 5;
  // Register B bits
  localparam int B_RXCIE = 7;
  localparam int B_TXCIE = 6;
  localparam int B_DREIE = 5;
  localparam int B_RXEN  = 4;
  localparam int B_TXEN  = 3;
  localparam int B_CSZ2  = 2;
  // Register C bits
  localparam int C_CSZ1 = 2;
  localparam int C_CSZ0 = 1;
  // Interrupt line bits
  localparam int IRQ_RX = 0;
  localparam int IRQ_TX = 1;
  localparam int IRQ_DE = 2;

  localparam logic [7:0] A_WR_MASK   = 8'h03;
  localparam logic [7:0] A_KEEP_MASK = 8'hBC;
  localparam logic [7:0] B_WR_MASK   = 8'hFD;
  localparam logic [7:0] B_KEEP_MASK = 8'h02;
  localparam logic [7:0] A_RESET     = 8'h20;
  localparam logic [7:0] B_RESET     = 8'h00;
  localparam logic [7:0] C_RESET     = 8'h06;
  localparam logic [7:0] MASK_RESET  = 8'hFF;
  localparam logic [4:0] FRAME_TAG   = 5'b00010;
  localparam logic [1:0] FRAME_LEN   = 2'd2;

  typedef struct packed {
    logic [2:0] rx_pin_number;
    logic [3:0] rx_port_index;
    logic [2:0] tx_pin_number;
    logic [3:0] tx_port_index;
  } cfg_t;

  typedef struct packed {
    logic       power_level;
    logic [3:0] port_index;
    logic [2:0] pin_number;
    logic [7:0] data_in;
    logic [2:0] reg_offset;
    logic [2:0] req_type;
  } req_t;

  // Packed so that read_data lands in the lowest bits
  typedef struct packed {
    logic       pin_active;
    logic       rx_ready;
    logic       pin_error;
    logic [1:0] frame_length;
    logic [7:0] frame_data;
    logic [7:0] frame_header;
    logic       tx_start;
    logic       data_empty_irq;
    logic       tx_complete_irq;
    logic       rx_complete_irq;
    logic [7:0] read_data;
  } rsp_t;

  function automatic logic [7:0] size_mask(input logic csz2, input logic csz1,
                                           input logic csz0, input logic [7:0] cur);
    logic [7:0] m;
    case ({csz2, csz1, csz0})
      3'd0:    m = 8'h1F;
      3'd1:    m = 8'h3F;
      3'd2:    m = 8'h7F;
      3'd3:    m = 8'hFF;
      3'd7:    m = 8'hFF;
      default: m = cur;
    endcase
    return m;
  endfunction

endpackage

>>> design/usart_ri_regs.sv
// Register file and single-pass update logic of the USART register interface.
// Depends on usart_ri_pkg.
module usart_ri_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  usart_ri_pkg::req_t  req,
  input  usart_ri_pkg::cfg_t  cfg,
  output usart_ri_pkg::rsp_t  rsp
);

  logic [7:0] ctrl_a, ctrl_a_next;
  logic [7:0] ctrl_b, ctrl_b_next;
  logic [7:0] ctrl_c, ctrl_c_next;
  logic [7:0] baud_low, baud_low_next;
  logic [3:0] baud_high, baud_high_next;
  logic [7:0] data_byte, data_byte_next;
  logic       rx_full, rx_full_next;
  logic [7:0] rx_mask, rx_mask_next;
  logic       enabled, enabled_next;
  logic [2:0] irq, irq_next;
  logic       rx_match, tx_match;

  assign rx_match = (req.pin_number == cfg.rx_pin_number) &&
                    (req.port_index == cfg.rx_port_index);
  assign tx_match = (req.pin_number == cfg.tx_pin_number) &&
                    (req.port_index == cfg.tx_port_index);

  always_comb begin
    ctrl_a_next     = ctrl_a;
    ctrl_b_next     = ctrl_b;
    ctrl_c_next     = ctrl_c;
    baud_low_next   = baud_low;
    baud_high_next  = baud_high;
    data_byte_next  = data_byte;
    rx_full_next    = rx_full;
    rx_mask_next    = rx_mask;
    enabled_next    = enabled;
    irq_next        = irq;
    rsp             = '0;

    case (req.req_type)
      usart_ri_pkg::REQ_READ: begin
        if (enabled) begin
          case (req.reg_offset)
            usart_ri_pkg::OFF_DATA: begin
              if (ctrl_b[usart_ri_pkg::B_RXEN]) begin
                if (rx_full) begin
                  rsp.read_data = data_byte & rx_mask;
                  rx_full_next  = 1'b0;
                end
                ctrl_a_next[usart_ri_pkg::A_RXC] = 1'b0;
                irq_next[usart_ri_pkg::IRQ_RX]   = 1'b0;
              end
            end
            usart_ri_pkg::OFF_CTRL_A:    rsp.read_data = ctrl_a;
            usart_ri_pkg::OFF_CTRL_B:    rsp.read_data = ctrl_b;
            usart_ri_pkg::OFF_CTRL_C:    rsp.read_data = ctrl_c;
            usart_ri_pkg::OFF_BAUD_LOW:  rsp.read_data = baud_low;
            usart_ri_pkg::OFF_BAUD_HIGH: rsp.read_data = {4'b0000, baud_high};
            default:                     rsp.read_data = 8'h00;
          endcase
        end
      end
      usart_ri_pkg::REQ_WRITE: begin
        if (enabled) begin
          case (req.reg_offset)
            usart_ri_pkg::OFF_DATA: begin
              if (ctrl_b[usart_ri_pkg::B_TXEN]) begin
                ctrl_a_next[usart_ri_pkg::A_TXC] = 1'b1;
                ctrl_a_next[usart_ri_pkg::A_DRE] = 1'b1;
                if (ctrl_b[usart_ri_pkg::B_TXCIE]) begin
                  irq_next[usart_ri_pkg::IRQ_TX]   = 1'b1;
                  ctrl_a_next[usart_ri_pkg::A_TXC] = 1'b0;
                end
                if (ctrl_b[usart_ri_pkg::B_DREIE]) begin
                  irq_next[usart_ri_pkg::IRQ_DE] = 1'b1;
                end
                data_byte_next = req.data_in;
                rsp.tx_start   = 1'b1;
              end
            end
            usart_ri_pkg::OFF_CTRL_A: begin
              ctrl_a_next = (req.data_in & usart_ri_pkg::A_WR_MASK) |
                            (ctrl_a & usart_ri_pkg::A_KEEP_MASK);
              if (req.data_in[usart_ri_pkg::A_TXC]) begin
                ctrl_a_next[usart_ri_pkg::A_TXC] = 1'b0;
                irq_next[usart_ri_pkg::IRQ_TX]   = 1'b0;
              end
            end
            usart_ri_pkg::OFF_CTRL_B: begin
              ctrl_b_next = (req.data_in & usart_ri_pkg::B_WR_MASK) |
                            (ctrl_b & usart_ri_pkg::B_KEEP_MASK);
              if (!ctrl_b_next[usart_ri_pkg::B_RXEN]) begin
                rx_full_next = 1'b0;
              end
              irq_next[usart_ri_pkg::IRQ_RX] = ctrl_b_next[usart_ri_pkg::B_RXCIE] &
                                               ctrl_a[usart_ri_pkg::A_RXC];
              irq_next[usart_ri_pkg::IRQ_TX] = ctrl_b_next[usart_ri_pkg::B_TXCIE] &
                                               ctrl_a[usart_ri_pkg::A_TXC];
              irq_next[usart_ri_pkg::IRQ_DE] = ctrl_b_next[usart_ri_pkg::B_DREIE] &
                                               ctrl_a[usart_ri_pkg::A_DRE];
              rx_mask_next = usart_ri_pkg::size_mask(ctrl_b_next[usart_ri_pkg::B_CSZ2],
                                                     ctrl_c[usart_ri_pkg::C_CSZ1],
                                                     ctrl_c[usart_ri_pkg::C_CSZ0],
                                                     rx_mask);
            end
            usart_ri_pkg::OFF_CTRL_C: begin
              ctrl_c_next  = req.data_in;
              rx_mask_next = usart_ri_pkg::size_mask(ctrl_b[usart_ri_pkg::B_CSZ2],
                                                     req.data_in[usart_ri_pkg::C_CSZ1],
                                                     req.data_in[usart_ri_pkg::C_CSZ0],
                                                     rx_mask);
            end
            usart_ri_pkg::OFF_BAUD_LOW:  baud_low_next  = req.data_in;
            usart_ri_pkg::OFF_BAUD_HIGH: baud_high_next = req.data_in[3:0];
            default: ;
          endcase
        end
      end
      usart_ri_pkg::REQ_RX: begin
        if (!rx_match) begin
          rsp.pin_error = 1'b1;
        end else begin
          data_byte_next = req.data_in;
          rx_full_next   = 1'b1;
          ctrl_a_next[usart_ri_pkg::A_RXC] = 1'b1;
          if (ctrl_b[usart_ri_pkg::B_RXCIE]) begin
            irq_next[usart_ri_pkg::IRQ_RX] = 1'b1;
          end
        end
      end
      usart_ri_pkg::REQ_POWER: begin
        enabled_next = !req.power_level;
        if (req.power_level) begin
          rx_full_next    = 1'b0;
          ctrl_a_next     = usart_ri_pkg::A_RESET;
          ctrl_b_next     = usart_ri_pkg::B_RESET;
          ctrl_c_next     = usart_ri_pkg::C_RESET;
          baud_low_next   = 8'h00;
          baud_high_next  = 4'h0;
          rx_mask_next    = usart_ri_pkg::MASK_RESET;
          irq_next        = 3'b000;
        end
      end
      usart_ri_pkg::REQ_FRAME: begin
        if (!tx_match) begin
          rsp.pin_error = 1'b1;
        end else begin
          rsp.frame_header = {req.pin_number, usart_ri_pkg::FRAME_TAG};
          rsp.frame_data   = data_byte;
          rsp.frame_length = usart_ri_pkg::FRAME_LEN;
        end
      end
      default: ;
    endcase

    rsp.rx_complete_irq = irq_next[usart_ri_pkg::IRQ_RX];
    rsp.tx_complete_irq = irq_next[usart_ri_pkg::IRQ_TX];
    rsp.data_empty_irq  = irq_next[usart_ri_pkg::IRQ_DE];
    rsp.rx_ready        = !rx_full_next && ctrl_b_next[usart_ri_pkg::B_RXEN];
    rsp.pin_active      = (rx_match && ctrl_b_next[usart_ri_pkg::B_RXEN]) ||
                          (tx_match && ctrl_b_next[usart_ri_pkg::B_TXEN]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a     <= usart_ri_pkg::A_RESET;
      ctrl_b     <= usart_ri_pkg::B_RESET;
      ctrl_c     <= usart_ri_pkg::C_RESET;
      baud_low   <= 8'h00;
      baud_high  <= 4'h0;
      data_byte  <= 8'h00;
      rx_full    <= 1'b0;
      rx_mask    <= usart_ri_pkg::MASK_RESET;
      enabled    <= 1'b1;
      irq        <= 3'b000;
    end else if (advance) begin
      ctrl_a     <= ctrl_a_next;
      ctrl_b     <= ctrl_b_next;
      ctrl_c     <= ctrl_c_next;
      baud_low   <= baud_low_next;
      baud_high  <= baud_high_next;
      data_byte  <= data_byte_next;
      rx_full    <= rx_full_next;
      rx_mask    <= rx_mask_next;
      enabled    <= enabled_next;
      irq        <= irq_next;
    end
  end

endmodule

>>> design/usart_register_interface_top.sv
// Top level of the USART register interface: stream handshake, input and result
// registers, pin configuration. Depends on usart_ri_pkg and usart_ri_regs.
//
//   channel  direction  ports                          payload
//   s_       in         s_tvalid s_tready s_tdata      request transaction, tuser = req_type
//   m_       out        m_tvalid m_tready m_tdata      one result per request
//   cfg_     in         cfg_wr_en cfg_index cfg_data   pin assignment writes
//
// One transaction per cycle sustained while the m_ side takes results; a result passes
// through the input register, then the result register, before it is offered on m_; the
// update is one pass of logic over the register file. rst is synchronous and clears
// both stage valids, the pin configuration and the register file, not the stage data.
// A stalled m_ side holds the result; s_tready drops only when both stages are full.
module usart_register_interface_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // reg_offset, data_in, pin_number, port_index, power_level
  input  logic [2:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data, rx_complete_irq, tx_complete_irq,
                                 // data_empty_irq, tx_start, frame_header, frame_data,
                                 // frame_length, pin_error, rx_ready, pin_active
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  usart_ri_pkg::cfg_t cfg;
  usart_ri_pkg::req_t in_req;
  usart_ri_pkg::rsp_t rsp;
  usart_ri_pkg::rsp_t out_rsp;
  logic               in_valid;
  logic               out_valid;
  logic               advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0000000, out_rsp};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_pin_number <= 3'd0;
      cfg.rx_port_index <= 4'd0;
      cfg.tx_pin_number <= 3'd1;
      cfg.tx_port_index <= 4'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        usart_ri_pkg::CFG_RX_PIN:  cfg.rx_pin_number <= cfg_data[2:0];
        usart_ri_pkg::CFG_RX_PORT: cfg.rx_port_index <= cfg_data;
        usart_ri_pkg::CFG_TX_PIN:  cfg.tx_pin_number <= cfg_data[2:0];
        usart_ri_pkg::CFG_TX_PORT: cfg.tx_port_index <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.req_type    <= s_tuser;
      in_req.reg_offset  <= s_tdata[2:0];
      in_req.data_in     <= s_tdata[10:3];
      in_req.pin_number  <= s_tdata[13:11];
      in_req.port_index  <= s_tdata[17:14];
      in_req.power_level <= s_tdata[18];
    end
  end

  usart_ri_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (in_req),
    .cfg     (cfg),
    .rsp     (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= rsp;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled while a stage is free");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");

  a_frame_no_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_rsp.frame_length != 2'd0 && out_rsp.pin_error))
    else $error("frame produced with pin error");

  a_start_excl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_rsp.tx_start) |-> (out_rsp.read_data == 8'h00 &&
                                        out_rsp.frame_length == 2'd0 &&
                                        !out_rsp.pin_error))
    else $error("tx_start mixed with other result kinds");
`endif

endmodule

>>> tb/usart_ri_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the USART register interface testbench: a register-file predictor
// and an in-order check of the result stream. Depends on usart_ri_pkg.
package usart_ri_tb_pkg;
  import usart_ri_pkg::*;

  class usart_ri_scoreboard;
    logic [2:0] rx_pin;
    logic [3:0] rx_port;
    logic [2:0] tx_pin;
    logic [3:0] tx_port;
    logic [7:0] reg_a;
    logic [7:0] reg_b;
    logic [7:0] reg_c;
    logic [7:0] baud_low;
    logic [3:0] baud_high;
    logic [7:0] data_byte;
    logic [7:0] rx_mask;
    logic [2:0] irq;
    logic       rx_full;
    logic       enabled;
    rsp_t       pending_results[$];
    int         mismatches;
    int         results_seen;

    function new();
      rx_pin       = 3'd0;
      rx_port      = 4'd0;
      tx_pin       = 3'd1;
      tx_port      = 4'd0;
      data_byte    = 8'h00;
      rx_mask      = MASK_RESET;
      enabled      = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      clear_regs();
    endfunction

    function void set_pin_cfg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        CFG_RX_PIN:  rx_pin = val[2:0];
        CFG_RX_PORT: rx_port = val;
        CFG_TX_PIN:  tx_pin = val[2:0];
        CFG_TX_PORT: tx_port = val;
        default: ;
      endcase
    endfunction

    function void refresh_rx_mask();
      case ({reg_b[B_CSZ2], reg_c[C_CSZ1], reg_c[C_CSZ0]})
        3'd0: rx_mask = 8'h1F;
        3'd1: rx_mask = 8'h3F;
        3'd2: rx_mask = 8'h7F;
        3'd3: rx_mask = 8'hFF;
        3'd7: rx_mask = 8'hFF;
        default: ;
      endcase
    endfunction

    // data_byte survives a power-reduce reset
    function void clear_regs();
      rx_full    = 1'b0;
      reg_a      = A_RESET;
      reg_b      = B_RESET;
      reg_c      = C_RESET;
      baud_low   = 8'h00;
      baud_high  = 4'h0;
      refresh_rx_mask();
      irq        = 3'b000;
    endfunction

    function logic [7:0] read_register(logic [2:0] off);
      logic [7:0] v;
      v = 8'h00;
      if (!enabled) return 8'h00;
      case (off)
        OFF_DATA: begin
          if (!reg_b[B_RXEN]) return 8'h00;
          if (rx_full) begin
            v = data_byte & rx_mask;
            rx_full = 1'b0;
          end
          reg_a[A_RXC] = 1'b0;
          irq[IRQ_RX]  = 1'b0;
        end
        OFF_CTRL_A:    v = reg_a;
        OFF_CTRL_B:    v = reg_b;
        OFF_CTRL_C:    v = reg_c;
        OFF_BAUD_LOW:  v = baud_low;
        OFF_BAUD_HIGH: v = {4'h0, baud_high};
        default:       v = 8'h00;
      endcase
      return v;
    endfunction

    function logic write_register(logic [2:0] off, logic [7:0] v);
      if (!enabled) return 1'b0;
      case (off)
        OFF_DATA: begin
          if (!reg_b[B_TXEN]) return 1'b0;
          reg_a[A_TXC] = 1'b1;
          reg_a[A_DRE] = 1'b1;
          if (reg_b[B_TXCIE]) begin
            irq[IRQ_TX]  = 1'b1;
            reg_a[A_TXC] = 1'b0;
          end
          if (reg_b[B_DREIE]) irq[IRQ_DE] = 1'b1;
          data_byte = v;
          return 1'b1;
        end
        OFF_CTRL_A: begin
          reg_a = (v & A_WR_MASK) | (reg_a & A_KEEP_MASK);
          if (v[A_TXC]) begin
            reg_a[A_TXC] = 1'b0;
            irq[IRQ_TX]  = 1'b0;
          end
        end
        OFF_CTRL_B: begin
          reg_b = (v & B_WR_MASK) | (reg_b & B_KEEP_MASK);
          if (!reg_b[B_RXEN]) rx_full = 1'b0;
          irq[IRQ_RX] = reg_b[B_RXCIE] && reg_a[A_RXC];
          irq[IRQ_TX] = reg_b[B_TXCIE] && reg_a[A_TXC];
          irq[IRQ_DE] = reg_b[B_DREIE] && reg_a[A_DRE];
          refresh_rx_mask();
        end
        OFF_CTRL_C: begin
          reg_c = v;
          refresh_rx_mask();
        end
        OFF_BAUD_LOW:  baud_low = v;
        OFF_BAUD_HIGH: baud_high = v[3:0];
        default: ;
      endcase
      return 1'b0;
    endfunction

    function rsp_t predict_response(req_t q);
      rsp_t r;
      logic rx_match;
      logic tx_match;
      r = '0;
      rx_match = (q.pin_number == rx_pin) && (q.port_index == rx_port);
      tx_match = (q.pin_number == tx_pin) && (q.port_index == tx_port);
      case (q.req_type)
        REQ_READ:  r.read_data = read_register(q.reg_offset);
        REQ_WRITE: r.tx_start = write_register(q.reg_offset, q.data_in);
        REQ_RX: begin
          if (!rx_match) begin
            r.pin_error = 1'b1;
          end else begin
            data_byte    = q.data_in;
            rx_full      = 1'b1;
            reg_a[A_RXC] = 1'b1;
            if (reg_b[B_RXCIE]) irq[IRQ_RX] = 1'b1;
          end
        end
        REQ_POWER: begin
          enabled = !q.power_level;
          if (!enabled) clear_regs();
        end
        REQ_FRAME: begin
          if (!tx_match) begin
            r.pin_error = 1'b1;
          end else begin
            r.frame_header = {q.pin_number, FRAME_TAG};
            r.frame_data   = data_byte;
            r.frame_length = FRAME_LEN;
          end
        end
        default: ;
      endcase
      r.rx_complete_irq = irq[IRQ_RX];
      r.tx_complete_irq = irq[IRQ_TX];
      r.data_empty_irq  = irq[IRQ_DE];
      r.rx_ready        = !rx_full && reg_b[B_RXEN];
      r.pin_active      = (rx_match && reg_b[B_RXEN]) || (tx_match && reg_b[B_TXEN]);
      return r;
    endfunction

    function void note_request(req_t q);
      pending_results.push_back(predict_response(q));
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 200) $display("MISMATCH %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got %h want %h",
                                  results_seen, name, got, want));
    endtask

    task check_result(logic [39:0] raw);
      rsp_t got;
      rsp_t want;
      got = raw[$bits(rsp_t)-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", raw));
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_data", got.read_data, want.read_data);
      compare_field("rx_complete_irq", got.rx_complete_irq, want.rx_complete_irq);
      compare_field("tx_complete_irq", got.tx_complete_irq, want.tx_complete_irq);
      compare_field("data_empty_irq", got.data_empty_irq, want.data_empty_irq);
      compare_field("tx_start", got.tx_start, want.tx_start);
      compare_field("frame_header", got.frame_header, want.frame_header);
      compare_field("frame_data", got.frame_data, want.frame_data);
      compare_field("frame_length", got.frame_length, want.frame_length);
      compare_field("pin_error", got.pin_error, want.pin_error);
      compare_field("rx_ready", got.rx_ready, want.rx_ready);
      compare_field("pin_active", got.pin_active, want.pin_active);
      results_seen++;
    endtask
  endclass

endpackage

>>> tb/usart_register_interface_top_test.sv
`timescale 1ns / 1ps
// Stream-level test of usart_register_interface_top: directed and random register,
// pin and power transactions checked against the scoreboard. Depends on usart_ri_pkg
// and usart_ri_tb_pkg.
module usart_register_interface_top_test;
  import usart_ri_pkg::*;
  import usart_ri_tb_pkg::*;

  localparam int         CYCLE_LIMIT   = 200_000;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         PHASE_ITEMS   = 112;
  localparam int         TAIL_CYCLES   = 8;
  localparam logic [2:0] OFF_GAP       = 3'd3;
  localparam logic [2:0] OFF_TOP       = 3'd7;
  localparam logic [2:0] REQ_SPARE     = 3'd5;
  localparam logic [2:0] REQ_SPARE_TOP = 3'd7;
  localparam logic [7:0] B_ENABLE_BITS = 8'h18;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // reg_offset, data_in, pin_number, port_index, power_level
  logic [2:0]  s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // read_data, rx_complete_irq, tx_complete_irq, data_empty_irq,
                          // tx_start, frame_header, frame_data, frame_length, pin_error,
                          // rx_ready, pin_active
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  bit          idle_on;
  bit          hold_pending;
  int          cycle_count;
  req_t        directed_reqs[$];

  usart_ri_scoreboard sb = new();

  usart_register_interface_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("usart_register_interface_top_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (!rst && s_tvalid && s_tready) sb.note_request(req_t'({s_tdata[18:0], s_tuser}));
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else begin
        m_tready <= !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [2:0] off, logic [7:0] din,
                                    logic [2:0] pin, logic [3:0] port, logic lvl);
    req_t q;
    q.req_type    = kind;
    q.reg_offset  = off;
    q.data_in     = din;
    q.pin_number  = pin;
    q.port_index  = port;
    q.power_level = lvl;
    return q;
  endfunction

  function automatic req_t random_request();
    req_t        q;
    bit [31:0]   r;
    int unsigned pick;
    int unsigned sel;
    logic [2:0]  offsets [6];
    r = $urandom;
    q = r[$bits(req_t)-1:0];
    offsets = '{OFF_CTRL_A, OFF_CTRL_B, OFF_CTRL_C, OFF_BAUD_LOW, OFF_BAUD_HIGH, OFF_DATA};
    pick = $urandom_range(99);
    if (!sb.enabled && pick < 20) begin
      q.req_type    = REQ_POWER;
      q.power_level = 1'b0;
      return q;
    end
    if (pick < 30) q.req_type = REQ_READ;
    else if (pick < 60) q.req_type = REQ_WRITE;
    else if (pick < 78) q.req_type = REQ_RX;
    else if (pick < 94) q.req_type = REQ_FRAME;
    else if (pick < 98) q.req_type = REQ_POWER;
    else q.req_type = 3'($urandom_range(REQ_SPARE_TOP, REQ_SPARE));
    case (q.req_type)
      REQ_READ, REQ_WRITE: begin
        sel = $urandom_range(9);
        if (sel < 6) q.reg_offset = offsets[sel];
        else if (sel < 9) q.reg_offset = OFF_DATA;
        else q.reg_offset = $urandom_range(1) ? OFF_GAP : OFF_TOP;
        if (q.req_type == REQ_WRITE && q.reg_offset == OFF_CTRL_B && $urandom_range(9) < 8)
          q.data_in = q.data_in | B_ENABLE_BITS;
      end
      REQ_RX: begin
        if ($urandom_range(99) < 85) begin
          q.pin_number = sb.rx_pin;
          q.port_index = sb.rx_port;
        end
      end
      REQ_FRAME: begin
        if ($urandom_range(99) < 85) begin
          q.pin_number = sb.tx_pin;
          q.port_index = sb.tx_port;
        end
      end
      REQ_POWER: q.power_level = ($urandom_range(99) < 40);
      default: ;
    endcase
    return q;
  endfunction

  task automatic send_request(input req_t q);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, q.power_level, q.port_index, q.pin_number, q.data_in, q.reg_offset};
    s_tuser  <= q.req_type;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_gap(input int unsigned n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(99) < 6) idle_gap(1);
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [3:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_pin_cfg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_pin_cfg(input logic [2:0] rxp, input logic [3:0] rxo,
                               input logic [2:0] txp, input logic [3:0] txo);
    wait_results_drained();
    write_cfg(CFG_RX_PIN, {1'b0, rxp});
    write_cfg(CFG_RX_PORT, rxo);
    write_cfg(CFG_TX_PIN, {1'b0, txp});
    write_cfg(CFG_TX_PORT, txo);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    idle_on      = 1'b1;
    hold_pending = 1'b0;
    cycle_count  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    apply_pin_cfg(3'd2, 4'd3, 3'd5, 4'd3);
    directed_reqs.push_back(make_req(REQ_READ, OFF_CTRL_A, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_READ, OFF_CTRL_C, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_CTRL_B, 8'hFF, 3'd7, 4'd15, 1'b1));
    directed_reqs.push_back(make_req(REQ_READ, OFF_CTRL_B, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_BAUD_LOW, 8'hFF, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_BAUD_HIGH, 8'hFF, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_READ, OFF_BAUD_HIGH, 8'h00, 3'd0, 4'd0, 1'b0));
    // reserved size code: mask holds
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_CTRL_C, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_RX, OFF_CTRL_A, 8'hA5, 3'd2, 4'd3, 1'b0));
    directed_reqs.push_back(make_req(REQ_READ, OFF_DATA, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_READ, OFF_DATA, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_CTRL_B, 8'hF8, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_RX, OFF_CTRL_A, 8'hFF, 3'd2, 4'd3, 1'b1));
    directed_reqs.push_back(make_req(REQ_READ, OFF_DATA, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_DATA, 8'h3C, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_CTRL_A, 8'hFF, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_FRAME, OFF_CTRL_A, 8'h00, 3'd5, 4'd3, 1'b0));
    directed_reqs.push_back(make_req(REQ_FRAME, OFF_CTRL_A, 8'h00, 3'd5, 4'd4, 1'b0));
    directed_reqs.push_back(make_req(REQ_RX, OFF_CTRL_A, 8'h11, 3'd2, 4'd15, 1'b0));
    directed_reqs.push_back(make_req(REQ_READ, OFF_GAP, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_TOP, 8'hFF, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_POWER, OFF_CTRL_A, 8'h00, 3'd0, 4'd0, 1'b1));
    directed_reqs.push_back(make_req(REQ_READ, OFF_CTRL_A, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_CTRL_B, 8'hFF, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_RX, OFF_CTRL_A, 8'h5A, 3'd2, 4'd3, 1'b0));
    directed_reqs.push_back(make_req(REQ_FRAME, OFF_CTRL_A, 8'h00, 3'd5, 4'd3, 1'b0));
    directed_reqs.push_back(make_req(REQ_POWER, OFF_CTRL_A, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_WRITE, OFF_DATA, 8'h77, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_READ, OFF_DATA, 8'h00, 3'd0, 4'd0, 1'b0));
    directed_reqs.push_back(make_req(REQ_SPARE, OFF_CTRL_A, 8'h00, 3'd5, 4'd3, 1'b0));
    directed_reqs.push_back(make_req(REQ_SPARE_TOP, OFF_DATA, 8'hFF, 3'd2, 4'd3, 1'b1));
    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i]);
      maybe_idle();
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: apply_pin_cfg(3'd0, 4'd0, 3'd1, 4'd0);
        1: apply_pin_cfg(3'd7, 4'd15, 3'd7, 4'd15);
        2: apply_pin_cfg(3'd0, 4'd15, 3'd7, 4'd0);
        default: apply_pin_cfg(3'($urandom_range(7)), 4'($urandom_range(15)),
                               3'($urandom_range(7)), 4'($urandom_range(15)));
      endcase
      idle_on = (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 30) hold_pending = 1'b1;
        if (phase == 1 && n == 50) wait_results_drained();
        send_request(random_request());
        maybe_idle();
      end
    end
    idle_on = 1'b1;

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.mismatches == 0) begin
      $display("usart_register_interface_top_test passed");
    end else begin
      $display("usart_register_interface_top_test failed");
    end
    $finish;
  end

endmodule
